/* hdl/gcpf_pkg.sv */
`default_nettype none
package gcpf_pkg;

	// Command kinds
	typedef enum logic [1:0] {
		KIND_STOP     = 2'd0,
		KIND_FAULT    = 2'd1,
		KIND_RATE     = 2'd2,
		KIND_ATTITUDE = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam logic [2:0] REG_HEADER   = 3'd0;
	localparam logic [2:0] REG_STOP     = 3'd1;
	localparam logic [2:0] REG_FAULT    = 3'd2;
	localparam logic [2:0] REG_RATE     = 3'd3;
	localparam logic [2:0] REG_ATTITUDE = 3'd4;

	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [24:0] TURN_Q     = 25'd23592960; // 360.0 in Q16.16
	localparam logic [12:0] TURN_RECIP = 13'd5826;     // ceil(2^18 / 45)
	localparam logic [14:0] TURN_BIAS  = 15'd4140;     // 45 * 92
	localparam logic [8:0]  TURN_OFFS  = 9'd92;
	localparam logic [3:0]  LAST_BYTE  = 4'd9;
	localparam logic [3:0]  CRC_LO     = 4'd8;

	// Live configuration
	typedef struct packed {
		logic [15:0] header_word;
		logic [7:0]  code_stop;
		logic [7:0]  code_fault;
		logic [7:0]  code_rate;
		logic [7:0]  code_attitude;
	} cfg_t;

	// One frame waiting for serialization
	typedef struct packed {
		logic [15:0] header_word;
		logic [7:0]  sequence_req;
		logic [7:0]  code;
		logic [15:0] yaw_word;
		logic [15:0] pitch_word;
	} frame_t;

	// floor(x / 360.0) for a Q16.16 value; 360.0 is 45 * 2^19
	function automatic logic signed [8:0] floor_turns(input logic signed [31:0] x);
		logic [14:0] tp;
		logic [26:0] prod;
		tp   = {{2{x[31]}}, x[31:19]} + TURN_BIAS;
		prod = 27'(tp[13:0]) * 27'(TURN_RECIP);
		return signed'(prod[26:18] - TURN_OFFS);
	endfunction

	// x - 360 * n with n nearest to x / 360, ties to even
	function automatic logic signed [25:0] wrap_turn(input logic signed [31:0] x,
			input logic signed [8:0] fl);
		logic signed [14:0] flm;
		logic signed [33:0] diff;
		logic [24:0] rem;
		logic [25:0] rem2;
		logic inc;
		flm  = 15'(fl) * 15'sd45;
		diff = 34'(x) - (34'(flm) <<< 19);
		rem  = diff[24:0];
		rem2 = {rem, 1'b0};
		inc  = (rem2 > {1'b0, TURN_Q}) || ((rem2 == {1'b0, TURN_Q}) && fl[0]);
		return inc ? signed'({1'b0, rem} - {1'b0, TURN_Q}) : signed'({1'b0, rem});
	endfunction

	// Q16.16 to int16, half away from zero, saturating
	function automatic logic [15:0] round_sat(input logic signed [38:0] p);
		logic [38:0] mag;
		logic [38:0] sum;
		logic [22:0] rnd;
		logic [15:0] res;
		mag = p[38] ? 39'(-p) : 39'(p);
		sum = mag + 39'd32768;
		rnd = sum[38:16];
		if (!p[38]) begin
			res = (rnd > 23'd32767) ? 16'h7FFF : rnd[15:0];
		end else begin
			res = (rnd > 23'd32768) ? 16'h8000 : 16'(16'd0 - rnd[15:0]);
		end
		return res;
	endfunction

	// CRC-16/MODBUS over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* hdl/gcpf_front.sv */
`default_nettype none
module gcpf_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [7:0]          sequence_req,
	input  wire logic [1:0]          kind,
	input  wire logic signed [31:0]  yaw_cmd,
	input  wire logic signed [31:0]  pitch_cmd,
	input  wire gcpf_pkg::cfg_t      cfg,
	output logic                     enq_valid,
	output gcpf_pkg::frame_t         enq_data,
	input  wire logic                enq_ready
);
	import gcpf_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	kind_t kind_s1, kind_s2, kind_s3, kind_s4;
	logic [7:0] seq_s1, seq_s2, seq_s3, seq_s4;
	logic [7:0] code_s1, code_s2, code_s3, code_s4;
	logic signed [31:0] x_s1 [2];
	logic signed [8:0]  fl_s1 [2];
	logic signed [31:0] v_val_s2 [2];
	logic signed [38:0] p_s3 [2];
	logic [15:0] word_s4 [2];
	logic [7:0] code_sel;
	logic send_words;

	// Whole pipeline moves when the last stage can drain
	assign adv  = !v_s4 || enq_ready;
	assign full = !adv;

	// Pick the mode byte for the incoming kind
	always_comb begin
		unique case (kind_t'(kind))
			KIND_STOP:     code_sel = cfg.code_stop;
			KIND_FAULT:    code_sel = cfg.code_fault;
			KIND_RATE:     code_sel = cfg.code_rate;
			KIND_ATTITUDE: code_sel = cfg.code_attitude;
			default:       code_sel = cfg.code_stop;
		endcase
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Advance payload: turn count, wrap and select, scale, round
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= kind_t'(kind);
			seq_s1   <= sequence_req;
			code_s1  <= code_sel;
			x_s1[0]  <= yaw_cmd;
			x_s1[1]  <= pitch_cmd;
			fl_s1[0] <= floor_turns(yaw_cmd);
			fl_s1[1] <= floor_turns(pitch_cmd);

			kind_s2 <= kind_s1;
			seq_s2  <= seq_s1;
			code_s2 <= code_s1;
			for (int i = 0; i < 2; i++) begin
				v_val_s2[i] <= (kind_s1 == KIND_ATTITUDE) ?
					32'(wrap_turn(x_s1[i], fl_s1[i])) : x_s1[i];
			end

			kind_s3 <= kind_s2;
			seq_s3  <= seq_s2;
			code_s3 <= code_s2;
			for (int i = 0; i < 2; i++) begin
				p_s3[i] <= 39'(v_val_s2[i]) * 39'sd100;
			end

			kind_s4 <= kind_s3;
			seq_s4  <= seq_s3;
			code_s4 <= code_s3;
			for (int i = 0; i < 2; i++) begin
				word_s4[i] <= round_sat(p_s3[i]);
			end
		end
	end

	// Stop and fault carry zero words
	assign send_words = (kind_s4 == KIND_RATE) || (kind_s4 == KIND_ATTITUDE);

	assign enq_valid             = v_s4;
	assign enq_data.header_word  = cfg.header_word;
	assign enq_data.sequence_req = seq_s4;
	assign enq_data.code         = code_s4;
	assign enq_data.yaw_word     = send_words ? word_s4[0] : 16'h0000;
	assign enq_data.pitch_word   = send_words ? word_s4[1] : 16'h0000;

endmodule
`default_nettype wire

/* hdl/gcpf_queue.sv */
`default_nettype none
module gcpf_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire gcpf_pkg::frame_t  wr_data,
	output logic                   rd_valid,
	input  wire logic              rd_take,
	output gcpf_pkg::frame_t       rd_data
);
	import gcpf_pkg::*;

	frame_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic do_wr, do_rd;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_take && rd_valid;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	// Store frames
	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

/* hdl/gcpf_back.sv */
`default_nettype none
module gcpf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              frm_valid,
	input  wire gcpf_pkg::frame_t  frm_data,
	output logic                   frm_take,
	output logic                   empty,
	input  wire logic              pop,
	output logic [7:0]             packet_byte,
	output logic                   last
);
	import gcpf_pkg::*;

	logic [3:0]  idx_q;
	logic [15:0] crc_q;
	logic        out_v_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [7:0]  cur_byte;
	logic        load;

	// Output register frees when empty or taken
	assign load     = frm_valid && (!out_v_q || pop);
	assign frm_take = load && (idx_q == LAST_BYTE);

	// Select the byte for the current position
	always_comb begin
		unique case (idx_q)
			4'd0:    cur_byte = frm_data.header_word[7:0];
			4'd1:    cur_byte = frm_data.header_word[15:8];
			4'd2:    cur_byte = frm_data.sequence_req;
			4'd3:    cur_byte = frm_data.code;
			4'd4:    cur_byte = frm_data.yaw_word[7:0];
			4'd5:    cur_byte = frm_data.yaw_word[15:8];
			4'd6:    cur_byte = frm_data.pitch_word[7:0];
			4'd7:    cur_byte = frm_data.pitch_word[15:8];
			CRC_LO:  cur_byte = crc_q[7:0];
			default: cur_byte = crc_q[15:8];
		endcase
	end

	// Step through the frame and fold bytes into the CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 4'd0;
			crc_q   <= CRC_INIT;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				if (idx_q == LAST_BYTE) begin
					idx_q <= 4'd0;
					crc_q <= CRC_INIT;
				end else begin
					idx_q <= idx_q + 4'd1;
					if (idx_q < CRC_LO) crc_q <= crc_byte(crc_q, cur_byte);
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Hold the byte on the output register
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= (idx_q == LAST_BYTE);
		end
	end

	assign empty       = !out_v_q;
	assign packet_byte = byte_q;
	assign last        = last_q;

endmodule
`default_nettype wire

/* hdl/gimbal_command_packet_framer.sv */
// Gimbal command framer: one command in, one 10-byte frame out.
// Command side: drive sequence_req, kind, yaw_cmd, pitch_cmd with push;
// a command is taken on a clock edge with push high and full low.
// Frame side: while empty is low, packet_byte/last show the oldest byte;
// pop takes it. Bytes go out least significant first, last marks the
// CRC high byte (tenth byte).
// Configuration: cfg_valid with cfg_index/cfg_data writes one register
// (0 header word, 1..4 mode bytes for stop, fault, rate, attitude);
// cfg_ready is always high, unknown indexes are dropped. Write only idle.
// Path: a taken command loads the first encode stage, passes three more, then
// the frame queue and the output register, where its first byte shows.
// Throughput: one byte per cycle while pop stays high, so the byte serializer
// sets the command rate; the encoder takes a command every cycle while full is
// low, and a 2-frame queue decouples it from the serializer.
// A stalled pop holds the output byte; the queue then fills and full rises.
// Reset clears the pipeline, queue and serializer and loads register
// defaults (header 0, mode bytes 0, 1, 2, 3).
`default_nettype none
module gimbal_command_packet_framer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [7:0]         sequence_req,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] yaw_cmd,
	input  wire logic signed [31:0] pitch_cmd,
	output logic                    empty,
	input  wire logic               pop,
	output logic [7:0]              packet_byte,
	output logic                    last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import gcpf_pkg::*;

	cfg_t   cfg_q;
	logic   enq_valid, enq_ready;
	frame_t enq_data;
	logic   frm_valid, frm_take;
	frame_t frm_data;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_word   <= 16'h0000;
			cfg_q.code_stop     <= 8'd0;
			cfg_q.code_fault    <= 8'd1;
			cfg_q.code_rate     <= 8'd2;
			cfg_q.code_attitude <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEADER:   cfg_q.header_word   <= cfg_data;
				REG_STOP:     cfg_q.code_stop     <= cfg_data[7:0];
				REG_FAULT:    cfg_q.code_fault    <= cfg_data[7:0];
				REG_RATE:     cfg_q.code_rate     <= cfg_data[7:0];
				REG_ATTITUDE: cfg_q.code_attitude <= cfg_data[7:0];
				default:      ;
			endcase
		end
	end

	gcpf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sequence_req (sequence_req),
		.kind         (kind),
		.yaw_cmd      (yaw_cmd),
		.pitch_cmd    (pitch_cmd),
		.cfg          (cfg_q),
		.enq_valid    (enq_valid),
		.enq_data     (enq_data),
		.enq_ready    (enq_ready)
	);

	gcpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (enq_valid),
		.wr_ready (enq_ready),
		.wr_data  (enq_data),
		.rd_valid (frm_valid),
		.rd_take  (frm_take),
		.rd_data  (frm_data)
	);

	gcpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frm_valid   (frm_valid),
		.frm_data    (frm_data),
		.frm_take    (frm_take),
		.empty       (empty),
		.pop         (pop),
		.packet_byte (packet_byte),
		.last        (last)
	);

endmodule
`default_nettype wire
